// File: hw/rtl/mbpws_pkg.sv
// Shared types, constants and lookup functions for the poll and write sequencer.
package mbpws_pkg;

   localparam int GROUP_COUNT = 14;
   localparam int MASK_W      = 14;
   localparam int CSR_W       = 16;
   localparam int CSR_IDX_W   = 2;
   localparam int POS_W       = 4;

   localparam logic [MASK_W-1:0] ENABLED_GROUPS_RESET = 14'h3FFF;
   localparam logic [15:0]       REPLY_TIMEOUT_RESET  = 16'd15000;
   localparam logic [15:0]       SEND_INTERVAL_RESET  = 16'd1000;

   localparam logic [CSR_IDX_W-1:0] CSR_ENABLED_GROUPS = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_REPLY_TIMEOUT  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_SEND_INTERVAL  = 2'd2;

   localparam logic [1:0] KIND_NONE  = 2'd0;
   localparam logic [1:0] KIND_READ  = 2'd1;
   localparam logic [1:0] KIND_WRITE = 2'd2;

   localparam logic [1:0] BUS_IDLE  = 2'd0;
   localparam logic [1:0] BUS_READ  = 2'd1;
   localparam logic [1:0] BUS_WRITE = 2'd2;

   localparam logic [4:0] FC_READ_HOLDING  = 5'd3;
   localparam logic [4:0] FC_READ_INPUT    = 5'd4;
   localparam logic [4:0] FC_WRITE_MULTIPLE = 5'd16;

   typedef enum logic [1:0] {
      EVT_TICK   = 2'd0,
      EVT_REPLY  = 2'd1,
      EVT_WRITE  = 2'd2,
      EVT_UPDATE = 2'd3
   } event_type;

   typedef enum logic [2:0] {
      OP_IDLE  = 3'b001,
      OP_READ  = 3'b010,
      OP_WRITE = 3'b100
   } op_mode_type;

   typedef struct packed {
      logic [4:0]  fc;
      logic [15:0] start;
      logic [15:0] count;
   } group_type;

   typedef struct packed {
      logic [15:0] addr;
      logic [15:0] value;
      logic        skip;
   } entry_type;

   localparam int ENTRY_W = $bits(entry_type);

   typedef struct packed {
      logic [1:0]  request_kind;
      logic [4:0]  function_code;
      logic [15:0] start_register;
      logic [15:0] count_or_value;
      logic [3:0]  group_index;
      logic        timed_out;
      logic        queue_overflow;
      logic [1:0]  bus_mode;
      logic        awaiting;
   } rsp_type;

   // Fixed register group table of the ventilation unit.
   function automatic group_type group_lookup(input logic [POS_W-1:0] idx);
      group_type g;
      begin
         unique case (idx)
            4'd0:    g = '{FC_READ_INPUT,   16'd0,    16'd4};
            4'd1:    g = '{FC_READ_INPUT,   16'd100,  16'd16};
            4'd2:    g = '{FC_READ_HOLDING, 16'd100,  16'd28};
            4'd3:    g = '{FC_READ_INPUT,   16'd200,  16'd23};
            4'd4:    g = '{FC_READ_INPUT,   16'd400,  16'd10};
            4'd5:    g = '{FC_READ_HOLDING, 16'd600,  16'd6};
            4'd6:    g = '{FC_READ_INPUT,   16'd1000, 16'd4};
            4'd7:    g = '{FC_READ_INPUT,   16'd1100, 16'd5};
            4'd8:    g = '{FC_READ_INPUT,   16'd1200, 16'd7};
            4'd9:    g = '{FC_READ_INPUT,   16'd1800, 16'd1};
            4'd10:   g = '{FC_READ_INPUT,   16'd2000, 16'd12};
            4'd11:   g = '{FC_READ_HOLDING, 16'd1200, 16'd6};
            4'd12:   g = '{FC_READ_HOLDING, 16'd1000, 16'd5};
            4'd13:   g = '{FC_READ_HOLDING, 16'd200,  16'd2};
            default: g = '{5'd0, 16'd0, 16'd0};
         endcase
         return g;
      end
   endfunction

   // Index of the lowest set bit, zero when none is set.
   function automatic logic [POS_W-1:0] lowest_set(input logic [MASK_W-1:0] mask);
      logic [POS_W-1:0] r;
      begin
         r = '0;
         for (int i = MASK_W - 1; i >= 0; i--) begin
            if (mask[i]) begin
               r = POS_W'(i);
            end
         end
         return r;
      end
   endfunction

   // Enabled groups strictly above the given position.
   function automatic logic [MASK_W-1:0] groups_above(input logic [MASK_W-1:0] mask,
                                                      input logic [POS_W-1:0] pos);
      logic [MASK_W-1:0] r;
      begin
         for (int i = 0; i < MASK_W; i++) begin
            r[i] = mask[i] && (POS_W'(i) > pos);
         end
         return r;
      end
   endfunction

   function automatic logic [1:0] bus_code(input op_mode_type m);
      logic [1:0] r;
      begin
         unique case (m)
            OP_READ:  r = BUS_READ;
            OP_WRITE: r = BUS_WRITE;
            default:  r = BUS_IDLE;
         endcase
         return r;
      end
   endfunction

endpackage

// File: hw/rtl/mbpws_ram.sv
// Generic single-write, single-read RAM with registered read data.
module mbpws_ram #(
   parameter int WIDTH = 33,
   parameter int DEPTH = 8
) (
   input  logic                                      clock,
   input  logic                                      wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                          wr_data,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                          rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// File: hw/rtl/modbus_poll_write_sequencer_core.sv
// Top level of the bus poll and write sequencer: event handling, write queue and result buffer.
//
//   channel  direction  handshake            payload
//   req_     in         req_valid/req_stall  mode, now_ms, reg_address, reg_value, skip_reply
//   rsp_     out        rsp_valid/rsp_stall  request_kind ... awaiting, one per transaction
//   csr_     in         csr_write_enable     csr_index, csr_wdata
//
// Every transaction is handled in the cycle it is accepted; its result is registered (output
// register or skid) and shown on rsp_; one transaction per cycle holds while rsp_stall is low.
// The write queue sits in a RAM with a one-entry lookahead of the head, fed by the
// registered read port and a write-to-read forwarding path.
// A two-entry result buffer (output register plus skid) lets one more transaction in
// while a result is stalled; req_stall rises only when both entries are full.
// Reset is synchronous and ready in the next cycle; queue contents need no clearing.
module modbus_poll_write_sequencer_core #(
   parameter int QUEUE_DEPTH = 8
) (
   input  logic                            clock,
   input  logic                            reset,

   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic [1:0]                      req_mode,
   input  logic [31:0]                     req_now_ms,
   input  logic [15:0]                     req_reg_address,
   input  logic [15:0]                     req_reg_value,
   input  logic                            req_skip_reply,

   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic [1:0]                      rsp_request_kind,
   output logic [4:0]                      rsp_function_code,
   output logic [15:0]                     rsp_start_register,
   output logic [15:0]                     rsp_count_or_value,
   output logic [3:0]                      rsp_group_index,
   output logic                            rsp_timed_out,
   output logic                            rsp_queue_overflow,
   output logic [1:0]                      rsp_bus_mode,
   output logic                            rsp_awaiting,

   input  logic                            csr_write_enable,
   input  logic [mbpws_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [mbpws_pkg::CSR_W-1:0]     csr_wdata
);

   localparam int PTR_W  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int FILL_W = $clog2(QUEUE_DEPTH + 1);
   localparam logic [PTR_W-1:0]  PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);
   localparam logic [FILL_W-1:0] FILL_MAX = FILL_W'(QUEUE_DEPTH);

   // configuration
   logic [mbpws_pkg::MASK_W-1:0] enabled_groups_ff, enabled_groups_in;
   logic [15:0]                  reply_timeout_ff, reply_timeout_in;
   logic [15:0]                  send_interval_ff, send_interval_in;

   // sequencer state
   mbpws_pkg::op_mode_type       op_mode_ff, op_mode_in;
   logic                         pending_ff, pending_in;
   logic [31:0]                  last_send_ff, last_send_in;
   logic [mbpws_pkg::POS_W-1:0]  read_pos_ff, read_pos_in;
   logic [FILL_W-1:0]            fill_ff, fill_in;
   logic [PTR_W-1:0]             head_ff, head_in;
   logic [PTR_W-1:0]             tail_ff, tail_in;

   // queue head lookahead
   logic                         fwd_ff, fwd_in;
   mbpws_pkg::entry_type         fwd_data_ff;
   logic [mbpws_pkg::ENTRY_W-1:0] ram_rd_data;
   mbpws_pkg::entry_type         head_entry;
   mbpws_pkg::entry_type         new_entry;
   logic                         ram_wr_en;

   // result buffer
   logic                         out_valid_ff, out_valid_in;
   mbpws_pkg::rsp_type           out_ff, out_in;
   logic                         skid_valid_ff, skid_valid_in;
   mbpws_pkg::rsp_type           skid_ff, skid_in;

   logic                         accept;
   logic                         out_free;
   mbpws_pkg::rsp_type           result;

   assign accept    = req_valid && !skid_valid_ff;
   assign req_stall = skid_valid_ff;

   assign new_entry.addr  = req_reg_address;
   assign new_entry.value = req_reg_value;
   assign new_entry.skip  = req_skip_reply;

   assign head_entry = fwd_ff ? fwd_data_ff : mbpws_pkg::entry_type'(ram_rd_data);

   always_comb begin
      logic [31:0]                  since;
      logic [31:0]                  since_tick;
      logic                         do_tick;
      logic [mbpws_pkg::MASK_W-1:0] above;
      mbpws_pkg::group_type         grp;
      mbpws_pkg::entry_type         pop_entry;

      op_mode_in   = op_mode_ff;
      pending_in   = pending_ff;
      last_send_in = last_send_ff;
      read_pos_in  = read_pos_ff;
      fill_in      = fill_ff;
      head_in      = head_ff;
      tail_in      = tail_ff;
      ram_wr_en    = 1'b0;
      result       = '0;
      do_tick      = 1'b0;
      since        = req_now_ms - last_send_ff;
      since_tick   = since;
      above        = mbpws_pkg::groups_above(enabled_groups_ff, read_pos_ff);
      grp          = mbpws_pkg::group_lookup(read_pos_ff);
      // an empty queue pops the entry that arrives in this very transaction
      pop_entry    = (fill_ff == '0) ? new_entry : head_entry;

      if (accept) begin
         unique case (mbpws_pkg::event_type'(req_mode))
            mbpws_pkg::EVT_TICK: begin
               do_tick = 1'b1;
            end
            mbpws_pkg::EVT_REPLY: begin
               pending_in = 1'b0;
               if (op_mode_ff == mbpws_pkg::OP_READ) begin
                  if (above != '0) begin
                     read_pos_in = mbpws_pkg::lowest_set(above);
                  end else begin
                     read_pos_in = mbpws_pkg::lowest_set(enabled_groups_ff);
                     op_mode_in  = mbpws_pkg::OP_IDLE;
                  end
               end
               if (fill_ff != '0) begin
                  op_mode_in = mbpws_pkg::OP_WRITE;
               end
            end
            mbpws_pkg::EVT_WRITE: begin
               if (fill_ff >= FILL_MAX) begin
                  result.queue_overflow = 1'b1;
               end else begin
                  ram_wr_en = 1'b1;
                  tail_in   = (tail_ff == PTR_LAST) ? '0 : tail_ff + 1'b1;
                  fill_in   = fill_ff + 1'b1;
               end
               if (op_mode_ff == mbpws_pkg::OP_IDLE) begin
                  op_mode_in = mbpws_pkg::OP_WRITE;
                  do_tick    = 1'b1;
               end
            end
            mbpws_pkg::EVT_UPDATE: begin
               if (op_mode_ff == mbpws_pkg::OP_IDLE) begin
                  op_mode_in = mbpws_pkg::OP_READ;
                  pending_in = 1'b0;
               end
            end
            default: begin
            end
         endcase

         if (do_tick) begin
            // timeout check comes before any send decision
            if (pending_in && (since_tick > {16'd0, reply_timeout_ff})) begin
               pending_in       = 1'b0;
               op_mode_in       = mbpws_pkg::OP_READ;
               fill_in          = '0;
               head_in          = '0;
               tail_in          = '0;
               result.timed_out = 1'b1;
            end
            if (!pending_in && !(since_tick < {16'd0, send_interval_ff})) begin
               last_send_in = req_now_ms;
               unique case (op_mode_in)
                  mbpws_pkg::OP_READ: begin
                     if ((read_pos_ff < mbpws_pkg::POS_W'(mbpws_pkg::GROUP_COUNT)) &&
                         enabled_groups_ff[read_pos_ff]) begin
                        pending_in            = 1'b1;
                        result.request_kind   = mbpws_pkg::KIND_READ;
                        result.function_code  = grp.fc;
                        result.start_register = grp.start;
                        result.count_or_value = grp.count;
                        result.group_index    = read_pos_ff;
                     end else begin
                        pending_in = 1'b0;
                     end
                  end
                  mbpws_pkg::OP_WRITE: begin
                     if (fill_in != '0) begin
                        result.request_kind   = mbpws_pkg::KIND_WRITE;
                        result.function_code  = mbpws_pkg::FC_WRITE_MULTIPLE;
                        result.start_register = pop_entry.addr;
                        result.count_or_value = pop_entry.value;
                        pending_in            = !pop_entry.skip;
                        head_in               = (head_ff == PTR_LAST) ? '0 : head_ff + 1'b1;
                        fill_in               = fill_in - 1'b1;
                     end else begin
                        op_mode_in = mbpws_pkg::OP_READ;
                     end
                  end
                  default: begin
                     pending_in = 1'b0;
                  end
               endcase
            end
         end
      end

      result.bus_mode = mbpws_pkg::bus_code(op_mode_in);
      result.awaiting = pending_in;
   end

   // forward a write that lands on the entry being read this cycle
   assign fwd_in = ram_wr_en && (tail_ff == head_in);

   always_comb begin
      enabled_groups_in = enabled_groups_ff;
      reply_timeout_in  = reply_timeout_ff;
      send_interval_in  = send_interval_ff;
      if (csr_write_enable) begin
         unique case (csr_index)
            mbpws_pkg::CSR_ENABLED_GROUPS: enabled_groups_in = csr_wdata[mbpws_pkg::MASK_W-1:0];
            mbpws_pkg::CSR_REPLY_TIMEOUT:  reply_timeout_in  = csr_wdata;
            mbpws_pkg::CSR_SEND_INTERVAL:  send_interval_in  = csr_wdata;
            default: begin
            end
         endcase
      end
   end

   // result buffer: output register with a skid entry behind it
   assign out_free = !out_valid_ff || !rsp_stall;

   always_comb begin
      out_valid_in  = out_valid_ff;
      out_in        = out_ff;
      skid_valid_in = skid_valid_ff;
      skid_in       = skid_ff;
      if (out_free) begin
         if (skid_valid_ff) begin
            out_valid_in  = 1'b1;
            out_in        = skid_ff;
            skid_valid_in = 1'b0;
         end else begin
            out_valid_in = accept;
            out_in       = result;
         end
      end else if (accept) begin
         skid_valid_in = 1'b1;
         skid_in       = result;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         enabled_groups_ff <= mbpws_pkg::ENABLED_GROUPS_RESET;
         reply_timeout_ff  <= mbpws_pkg::REPLY_TIMEOUT_RESET;
         send_interval_ff  <= mbpws_pkg::SEND_INTERVAL_RESET;
         op_mode_ff        <= mbpws_pkg::OP_IDLE;
         pending_ff        <= 1'b0;
         last_send_ff      <= '0;
         read_pos_ff       <= mbpws_pkg::lowest_set(mbpws_pkg::ENABLED_GROUPS_RESET);
         fill_ff           <= '0;
         head_ff           <= '0;
         tail_ff           <= '0;
         fwd_ff            <= 1'b0;
         out_valid_ff      <= 1'b0;
         skid_valid_ff     <= 1'b0;
      end else begin
         enabled_groups_ff <= enabled_groups_in;
         reply_timeout_ff  <= reply_timeout_in;
         send_interval_ff  <= send_interval_in;
         op_mode_ff        <= op_mode_in;
         pending_ff        <= pending_in;
         last_send_ff      <= last_send_in;
         // a new enable mask restarts the scan at its first group
         if (csr_write_enable && (csr_index == mbpws_pkg::CSR_ENABLED_GROUPS)) begin
            read_pos_ff <= mbpws_pkg::lowest_set(enabled_groups_in);
         end else begin
            read_pos_ff <= read_pos_in;
         end
         fill_ff           <= fill_in;
         head_ff           <= head_in;
         tail_ff           <= tail_in;
         fwd_ff            <= fwd_in;
         out_valid_ff      <= out_valid_in;
         skid_valid_ff     <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      fwd_data_ff <= new_entry;
      out_ff      <= out_in;
      skid_ff     <= skid_in;
   end

   mbpws_ram #(
      .WIDTH (mbpws_pkg::ENTRY_W),
      .DEPTH (QUEUE_DEPTH)
   ) u_queue_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (tail_ff),
      .wr_data (new_entry),
      .rd_addr (head_in),
      .rd_data (ram_rd_data)
   );

   assign rsp_valid          = out_valid_ff;
   assign rsp_request_kind   = out_ff.request_kind;
   assign rsp_function_code  = out_ff.function_code;
   assign rsp_start_register = out_ff.start_register;
   assign rsp_count_or_value = out_ff.count_or_value;
   assign rsp_group_index    = out_ff.group_index;
   assign rsp_timed_out      = out_ff.timed_out;
   assign rsp_queue_overflow = out_ff.queue_overflow;
   assign rsp_bus_mode       = out_ff.bus_mode;
   assign rsp_awaiting       = out_ff.awaiting;

endmodule
